// ===== hdl/pfl_pkg.sv =====
package pfl_pkg;

    localparam int BYTE_DEPTH   = 1024;
    localparam int PACKET_SLOTS = 16;
    localparam int MAX_PACKET   = 64;

    localparam int PTR_W  = $clog2(BYTE_DEPTH);
    localparam int CBC_W  = $clog2(BYTE_DEPTH + 1);
    localparam int SLOT_W = $clog2(PACKET_SLOTS);
    localparam int DCNT_W = $clog2(PACKET_SLOTS + 1);
    localparam int BIP_W  = $clog2(MAX_PACKET + 1);

    localparam int FQ_DEPTH = 2;
    localparam int FQ_W     = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    localparam int OQ_DEPTH = 4;
    localparam int OQ_W     = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_EDIT  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_TOO_SMALL = 3'd2;
    localparam logic [2:0] ST_MISMATCH  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_ID_DIFF   = 3'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data;
        logic        last;
        logic [6:0]  decl;
        logic [15:0] id;
        logic [15:0] bsize;
        logic        id_zero;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  data;
        logic [15:0] id;
        logic [6:0]  count;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } res_wr_t;

endpackage

// ===== hdl/pfl_front.sv =====
module pfl_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        operation,
    input  logic [7:0]        data_byte,
    input  logic              byte_last,
    input  logic [6:0]        declared_length,
    input  logic [15:0]       packet_id,
    input  logic [15:0]       buffer_size,
    output pfl_pkg::cmd_req_t cmd_req,
    input  logic              cmd_take
);
    import pfl_pkg::*;

    cmd_t             q_reg [FQ_DEPTH];
    cmd_t             incoming;
    logic [FQ_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FQ_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FQ_CW-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             take;

    assign full   = (cnt_reg == FQ_CW'(FQ_DEPTH));
    assign accept = push && !full;
    assign take   = cmd_take && (cnt_reg != '0);

    always_comb
    begin
        incoming.op      = operation;
        incoming.data    = data_byte;
        incoming.last    = byte_last;
        incoming.decl    = declared_length;
        incoming.id      = packet_id;
        incoming.bsize   = buffer_size;
        incoming.id_zero = (packet_id == 16'd0);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == FQ_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr_reg + FQ_W'(1);
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == FQ_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr_reg + FQ_W'(1);
        end
        if (accept && !take)
        begin
            cnt_next = cnt_reg + FQ_CW'(1);
        end
        else if (take && !accept)
        begin
            cnt_next = cnt_reg - FQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= incoming;
        end
    end

    assign cmd_req.valid = (cnt_reg != '0);
    assign cmd_req.cmd   = q_reg[rd_ptr_reg];

endmodule

// ===== hdl/pfl_outq.sv =====
module pfl_outq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pfl_pkg::res_wr_t          res_wr,
    output logic [pfl_pkg::OQ_CW-1:0] res_free,
    input  logic                      pop,
    output logic                      empty,
    output pfl_pkg::result_t          head
);
    import pfl_pkg::*;

    result_t          q_reg [OQ_DEPTH];
    logic [OQ_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OQ_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OQ_CW-1:0] cnt_reg, cnt_next;
    logic             rd;

    assign empty    = (cnt_reg == '0);
    assign rd       = pop && !empty;
    assign res_free = OQ_CW'(OQ_DEPTH) - cnt_reg;
    assign head     = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (res_wr.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == OQ_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_reg + OQ_W'(1);
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == OQ_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_reg + OQ_W'(1);
        end
        if (res_wr.valid && !rd)
        begin
            cnt_next = cnt_reg + OQ_CW'(1);
        end
        else if (rd && !res_wr.valid)
        begin
            cnt_next = cnt_reg - OQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_wr.valid)
        begin
            q_reg[wr_ptr_reg] <= res_wr.res;
        end
    end

endmodule

// ===== hdl/pfl_back.sv =====
module pfl_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pfl_pkg::cmd_req_t         cmd_req,
    output logic                      cmd_take,
    input  logic [pfl_pkg::OQ_CW-1:0] res_free,
    output pfl_pkg::res_wr_t          res_wr
);
    import pfl_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic [7:0]        mem [BYTE_DEPTH];
    logic [15:0]       desc_id [PACKET_SLOTS];
    logic [6:0]        desc_len [PACKET_SLOTS];

    logic              state_reg, state_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [CBC_W-1:0]  cbc_reg, cbc_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [BIP_W-1:0]  bip_reg, bip_next;
    logic [BIP_W-1:0]  rem_reg, rem_next;
    logic [15:0]       pop_id_reg, pop_id_next;
    logic [6:0]        pop_len_reg, pop_len_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              rd_last_reg, rd_last_next;
    logic [7:0]        rd_data_reg;

    cmd_t              cmd;
    result_t           sres;
    logic              single;
    logic              can_take;
    logic              can_issue;
    logic              mem_we;
    logic              mem_re;
    logic              desc_we;
    logic              desc_id_we;
    logic              fin;
    logic [6:0]        fin_len;
    logic [15:0]       head_id;
    logic [6:0]        head_len;
    logic [6:0]        hlen_c;
    logic              too_small;
    logic [PTR_W-1:0]  wp_inc;
    logic [PTR_W-1:0]  rp_inc;
    logic [PTR_W:0]    wp_x;
    logic [PTR_W:0]    bip_x;
    logic [PTR_W:0]    rb_x;
    logic [PTR_W-1:0]  rb_wp;
    logic [BIP_W-1:0]  bip_inc;
    logic [CBC_W:0]    used;
    logic              bytes_full;
    logic              too_long;
    logic              len_bad;
    logic              desc_full;
    logic [DCNT_W:0]   slot_sum;
    logic [DCNT_W:0]   slot_x;
    logic [SLOT_W-1:0] slot;

    assign cmd       = cmd_req.cmd;
    assign head_id   = desc_id[head_reg];
    assign head_len  = desc_len[head_reg];
    assign hlen_c    = (head_len > 7'(MAX_PACKET)) ? 7'(MAX_PACKET) : head_len;
    assign too_small = (cmd.bsize < 16'(head_len));

    assign wp_inc = (wp_reg == PTR_W'(BYTE_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
    assign rp_inc = (rp_reg == PTR_W'(BYTE_DEPTH - 1)) ? '0 : rp_reg + PTR_W'(1);
    assign wp_x   = (PTR_W + 1)'(wp_reg);
    assign bip_x  = (PTR_W + 1)'(bip_reg);
    assign rb_x   = (wp_x >= bip_x) ? wp_x - bip_x
                                    : wp_x + (PTR_W + 1)'(BYTE_DEPTH) - bip_x;
    assign rb_wp  = rb_x[PTR_W-1:0];

    assign bip_inc    = bip_reg + BIP_W'(1);
    assign used       = (CBC_W + 1)'(cbc_reg) + (CBC_W + 1)'(bip_reg);
    assign bytes_full = (used >= (CBC_W + 1)'(BYTE_DEPTH));
    assign too_long   = (bip_reg >= BIP_W'(MAX_PACKET));
    assign len_bad    = (8'(bip_inc) != 8'(cmd.decl));
    assign desc_full  = (dcnt_reg >= DCNT_W'(PACKET_SLOTS));
    assign slot_sum   = (DCNT_W + 1)'(head_reg) + (DCNT_W + 1)'(dcnt_reg);
    assign slot_x     = (slot_sum >= (DCNT_W + 1)'(PACKET_SLOTS))
                        ? slot_sum - (DCNT_W + 1)'(PACKET_SLOTS) : slot_sum;
    assign slot       = slot_x[SLOT_W-1:0];

    assign can_take  = cmd_req.valid && (state_reg == S_IDLE) && !rd_pend_reg
                       && (res_free != '0);
    assign can_issue = (state_reg == S_POP) && (res_free > OQ_CW'(rd_pend_reg));
    assign cmd_take  = can_take;

    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        cbc_next     = cbc_reg;
        head_next    = head_reg;
        dcnt_next    = dcnt_reg;
        bip_next     = bip_reg;
        rem_next     = rem_reg;
        pop_id_next  = pop_id_reg;
        pop_len_next = pop_len_reg;
        rd_pend_next = 1'b0;
        rd_last_next = rd_last_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        desc_we      = 1'b0;
        desc_id_we   = 1'b0;
        fin          = 1'b0;
        fin_len      = '0;
        single       = 1'b0;
        sres         = '0;
        sres.last    = 1'b1;

        if (can_take)
        begin
            single = 1'b1;
            case (cmd.op)
                OP_PUSH:
                begin
                    if (too_long)
                    begin
                        wp_next     = rb_wp;
                        bip_next    = '0;
                        sres.status = ST_MISMATCH;
                    end
                    else if (bytes_full)
                    begin
                        wp_next     = rb_wp;
                        bip_next    = '0;
                        sres.status = ST_FULL;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (!cmd.last)
                        begin
                            wp_next     = wp_inc;
                            bip_next    = bip_inc;
                            sres.status = ST_OK;
                        end
                        else if (len_bad)
                        begin
                            wp_next     = rb_wp;
                            bip_next    = '0;
                            sres.status = ST_MISMATCH;
                        end
                        else if (desc_full)
                        begin
                            wp_next     = rb_wp;
                            bip_next    = '0;
                            sres.status = ST_FULL;
                        end
                        else
                        begin
                            desc_we     = 1'b1;
                            wp_next     = wp_inc;
                            bip_next    = '0;
                            dcnt_next   = dcnt_reg + DCNT_W'(1);
                            cbc_next    = cbc_reg + CBC_W'(bip_inc);
                            sres.status = ST_OK;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    wp_next     = '0;
                    rp_next     = '0;
                    cbc_next    = '0;
                    head_next   = '0;
                    dcnt_next   = '0;
                    bip_next    = '0;
                    sres.status = ST_OK;
                end
                OP_EDIT:
                begin
                    if (dcnt_reg == '0)
                    begin
                        sres.status = ST_EMPTY;
                    end
                    else
                    begin
                        desc_id_we  = !cmd.id_zero;
                        sres.id     = cmd.id_zero ? head_id : cmd.id;
                        sres.count  = head_len;
                        sres.status = (cmd.id_zero && (head_id != 16'd0)) ? ST_ID_DIFF : ST_OK;
                    end
                end
                OP_POP:
                begin
                    if (dcnt_reg == '0)
                    begin
                        sres.status = ST_EMPTY;
                    end
                    else if (too_small)
                    begin
                        sres.status = ST_TOO_SMALL;
                        sres.id     = head_id;
                        sres.count  = head_len;
                    end
                    else if (hlen_c == '0)
                    begin
                        fin         = 1'b1;
                        sres.status = ST_OK;
                        sres.id     = head_id;
                    end
                    else
                    begin
                        single       = 1'b0;
                        state_next   = S_POP;
                        rem_next     = BIP_W'(hlen_c);
                        pop_id_next  = head_id;
                        pop_len_next = hlen_c;
                    end
                end
                default:
                begin
                    sres.status = ST_OK;
                end
            endcase
        end

        if (can_issue)
        begin
            mem_re       = 1'b1;
            rp_next      = rp_inc;
            rem_next     = rem_reg - BIP_W'(1);
            rd_pend_next = 1'b1;
            rd_last_next = (rem_reg == BIP_W'(1));
            if (rem_reg == BIP_W'(1))
            begin
                state_next = S_IDLE;
                fin        = 1'b1;
                fin_len    = pop_len_reg;
            end
        end

        if (fin)
        begin
            head_next = (head_reg == SLOT_W'(PACKET_SLOTS - 1)) ? '0 : head_reg + SLOT_W'(1);
            dcnt_next = dcnt_reg - DCNT_W'(1);
            cbc_next  = (cbc_reg >= CBC_W'(fin_len)) ? cbc_reg - CBC_W'(fin_len) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wp_reg      <= '0;
            rp_reg      <= '0;
            cbc_reg     <= '0;
            head_reg    <= '0;
            dcnt_reg    <= '0;
            bip_reg     <= '0;
            rem_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            cbc_reg     <= cbc_next;
            head_reg    <= head_next;
            dcnt_reg    <= dcnt_next;
            bip_reg     <= bip_next;
            rem_reg     <= rem_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_id_reg  <= pop_id_next;
        pop_len_reg <= pop_len_next;
        rd_last_reg <= rd_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= cmd.data;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rp_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_we)
        begin
            desc_id[slot]  <= cmd.id;
            desc_len[slot] <= cmd.decl;
        end
        if (desc_id_we)
        begin
            desc_id[head_reg] <= cmd.id;
        end
    end

    always_comb
    begin
        res_wr.valid = single || rd_pend_reg;
        if (rd_pend_reg)
        begin
            res_wr.res.status = ST_OK;
            res_wr.res.data   = rd_data_reg;
            res_wr.res.id     = pop_id_reg;
            res_wr.res.count  = pop_len_reg;
            res_wr.res.last   = rd_last_reg;
        end
        else
        begin
            res_wr.res = sres;
        end
    end

endmodule

// ===== hdl/packet_fifo_with_length_check.sv =====
// Packet buffer with a length check on every stored packet.
// Requests enter through a queue-style port: a request is taken when push is
// high and full is low. Results leave the same way: the oldest result is on
// the result ports while empty is low and is taken when pop is high.
// Push, clear and edit requests give one result each; a pop request gives
// one result per byte of the head packet, or one status result when the
// queue is empty or the reader's buffer is too small.
// A request is taken into a two-entry front queue. A single-result request
// has its result written into the result queue as the back end takes it
// from the front queue. A pop request streams its bytes from the byte
// memory while the result queue has room, one byte per cycle, each through
// the memory's registered read port. A pop holds the back end until its last
// byte is read; other requests, when there is room, run at one per cycle.
// Reset empties both request and result queues and all packet state.
// When the receiver stalls, the four-entry result queue fills, the back end
// waits, and full rises once the front queue also fills; nothing is dropped.
module packet_fifo_with_length_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [7:0]  data_byte,
    input  logic        byte_last,
    input  logic [6:0]  declared_length,
    input  logic [15:0] packet_id,
    input  logic [15:0] buffer_size,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [7:0]  out_byte,
    output logic [15:0] out_packet_id,
    output logic [6:0]  out_count,
    output logic        out_last
);
    import pfl_pkg::*;

    cmd_req_t         cmd_req;
    logic             cmd_take;
    res_wr_t          res_wr;
    logic [OQ_CW-1:0] res_free;
    result_t          head;

    pfl_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .operation       (operation),
        .data_byte       (data_byte),
        .byte_last       (byte_last),
        .declared_length (declared_length),
        .packet_id       (packet_id),
        .buffer_size     (buffer_size),
        .cmd_req         (cmd_req),
        .cmd_take        (cmd_take)
    );

    pfl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_req  (cmd_req),
        .cmd_take (cmd_take),
        .res_free (res_free),
        .res_wr   (res_wr)
    );

    pfl_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_wr   (res_wr),
        .res_free (res_free),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    assign status        = head.status;
    assign out_byte      = head.data;
    assign out_packet_id = head.id;
    assign out_count     = head.count;
    assign out_last      = head.last;

    a_front_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !cmd_req.valid) |=> cmd_req.valid)
        else $error("Request taken into an empty front queue did not appear.");

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_wr.valid |-> (res_free != '0))
        else $error("Result written into a full result queue.");

    a_empty_by_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(empty) |-> $past(pop))
        else $error("Result queue emptied without a pop.");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import pfl_pkg::*;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data;
        logic        last;
        logic [6:0]  decl;
        logic [15:0] id;
        logic [15:0] bsize;
    } request_t;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        push            = 1'b0;
    logic        pop             = 1'b0;
    logic [1:0]  operation       = OP_PUSH;
    logic [7:0]  data_byte       = '0;
    logic        byte_last       = 1'b0;
    logic [6:0]  declared_length = '0;
    logic [15:0] packet_id       = '0;
    logic [15:0] buffer_size     = '0;
    logic        full;
    logic        empty;
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic [15:0] out_packet_id;
    logic [6:0]  out_count;
    logic        out_last;

    request_t    requests_to_send[$];
    result_t     results_due[$];
    result_t     due;
    int          send_idle_pct = 27;
    int          take_idle_pct = 85;
    int          error_count   = 0;
    int          cycle_count   = 0;

    logic [7:0]  mem_bytes [BYTE_DEPTH];
    logic [15:0] slot_id [PACKET_SLOTS];
    logic [6:0]  slot_len [PACKET_SLOTS];
    int unsigned rd_ptr       = 0;
    int unsigned wr_ptr       = 0;
    int unsigned stored_bytes = 0;
    int unsigned head_slot    = 0;
    int unsigned slot_count   = 0;
    int unsigned partial      = 0;

    packet_fifo_with_length_check u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .operation       (operation),
        .data_byte       (data_byte),
        .byte_last       (byte_last),
        .declared_length (declared_length),
        .packet_id       (packet_id),
        .buffer_size     (buffer_size),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .out_byte        (out_byte),
        .out_packet_id   (out_packet_id),
        .out_count       (out_count),
        .out_last        (out_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void drop_partial();
        wr_ptr  = (wr_ptr + BYTE_DEPTH - partial) % BYTE_DEPTH;
        partial = 0;
    endfunction

    function automatic logic [2:0] store_byte(input request_t r);
        int unsigned slot;
        if (partial >= MAX_PACKET)
        begin
            drop_partial();
            return ST_MISMATCH;
        end
        if (stored_bytes + partial >= BYTE_DEPTH)
        begin
            drop_partial();
            return ST_FULL;
        end
        mem_bytes[wr_ptr] = r.data;
        wr_ptr = (wr_ptr + 1) % BYTE_DEPTH;
        partial++;
        if (!r.last)
            return ST_OK;
        if (partial != r.decl)
        begin
            drop_partial();
            return ST_MISMATCH;
        end
        if (slot_count >= PACKET_SLOTS)
        begin
            drop_partial();
            return ST_FULL;
        end
        slot = (head_slot + slot_count) % PACKET_SLOTS;
        slot_id[slot]  = r.id;
        slot_len[slot] = r.decl;
        slot_count++;
        stored_bytes += r.decl;
        partial = 0;
        return ST_OK;
    endfunction

    task automatic run_request(input request_t r);
        result_t     res;
        logic [15:0] head_id;
        logic [6:0]  head_len;
        res      = '0;
        res.last = 1'b1;
        case (r.op)
            OP_PUSH:
                res.status = store_byte(r);
            OP_CLEAR:
            begin
                rd_ptr       = 0;
                wr_ptr       = 0;
                stored_bytes = 0;
                head_slot    = 0;
                slot_count   = 0;
                partial      = 0;
                res.status   = ST_OK;
            end
            default:
            begin
                if (slot_count == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    head_id  = slot_id[head_slot];
                    head_len = slot_len[head_slot];
                    res.id    = head_id;
                    res.count = head_len;
                    if (r.op == OP_EDIT)
                    begin
                        if (r.id != 0)
                        begin
                            head_id = r.id;
                            slot_id[head_slot] = r.id;
                        end
                        res.id     = head_id;
                        res.status = (r.id == head_id) ? ST_OK : ST_ID_DIFF;
                    end
                    else if (r.bsize < head_len)
                        res.status = ST_TOO_SMALL;
                    else
                    begin
                        for (int i = 0; i < head_len; i++)
                        begin
                            res.status = ST_OK;
                            res.data   = mem_bytes[rd_ptr];
                            res.last   = (i == head_len - 1);
                            results_due.push_back(res);
                            rd_ptr = (rd_ptr + 1) % BYTE_DEPTH;
                        end
                        stored_bytes -= head_len;
                        head_slot = (head_slot + 1) % PACKET_SLOTS;
                        slot_count--;
                        return;
                    end
                end
            end
        endcase
        results_due.push_back(res);
    endtask

    function automatic void queue_request(input logic [1:0] op, input logic [7:0] data,
                                          input logic last, input logic [6:0] decl,
                                          input logic [15:0] id, input logic [15:0] bsize);
        request_t r;
        r.op    = op;
        r.data  = data;
        r.last  = last;
        r.decl  = decl;
        r.id    = id;
        r.bsize = bsize;
        requests_to_send.push_back(r);
    endfunction

    task automatic add_random_traffic(input int n);
        int          added;
        int          pick;
        int          len;
        logic [6:0]  final_decl;
        logic [15:0] pkt_id;
        logic [15:0] room;
        added = 0;
        while (added < n)
        begin
            pick   = $urandom_range(99);
            pkt_id = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom_range(65535));
            if (pick < 65)
            begin
                len = ($urandom_range(11) == 0) ? $urandom_range(64, 1) : $urandom_range(6, 1);
                final_decl = (pick < 52) ? 7'(len) : 7'($urandom_range(64));
                for (int i = 0; i < len; i++)
                    queue_request(OP_PUSH, 8'($urandom_range(255)), i == len - 1,
                                  (i == len - 1) ? final_decl : 7'($urandom_range(64)),
                                  pkt_id, 16'($urandom_range(65535)));
                added += len;
            end
            else if (pick < 90)
            begin
                case ($urandom_range(9))
                    0, 1: room = 16'($urandom_range(8));
                    2:    room = 16'($urandom_range(65535));
                    default: room = 16'($urandom_range(65535, 64));
                endcase
                queue_request(OP_POP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                              7'($urandom_range(64)), 16'($urandom_range(65535)), room);
                added++;
            end
            else if (pick < 96)
            begin
                queue_request(OP_EDIT, 8'($urandom_range(255)), 1'($urandom_range(1)),
                              7'($urandom_range(64)),
                              ($urandom_range(1) != 0) ? 16'h0000 : pkt_id,
                              16'($urandom_range(65535)));
                added++;
            end
            else if (pick < 98)
            begin
                queue_request(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                              7'($urandom_range(64)), 16'($urandom_range(65535)),
                              16'($urandom_range(65535)));
                added++;
            end
            else
            begin
                queue_request(OP_PUSH, 8'($urandom_range(255)), 1'($urandom_range(1)),
                              7'($urandom_range(64)), pkt_id, 16'($urandom_range(65535)));
                added++;
            end
        end
    endtask

    task automatic wait_until_idle();
        while (requests_to_send.size() != 0 || results_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && requests_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            push <= 1'b1;
            {operation, data_byte, byte_last, declared_length, packet_id, buffer_size}
                <= requests_to_send[0];
        end
        else
            push <= 1'b0;
        pop <= rst_n && ($urandom_range(99) >= take_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                run_request(requests_to_send.pop_front());
            if (pop && !empty)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result with status %0d arrived with none pending", status);
                    error_count++;
                end
                else
                begin
                    due = results_due.pop_front();
                    compare_field("status", due.status, status);
                    compare_field("out_byte", due.data, out_byte);
                    compare_field("out_packet_id", due.id, out_packet_id);
                    compare_field("out_count", due.count, out_count);
                    compare_field("out_last", due.last, out_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        int k;

        queue_request(OP_POP, 8'($urandom_range(255)), 1'b1, 7'd64, 16'hFFFF, 16'hFFFF);
        queue_request(OP_EDIT, 8'($urandom_range(255)), 1'b0, 7'd0, 16'hFFFF, 16'h0000);
        queue_request(OP_PUSH, 8'h00, 1'b1, 7'd0, 16'h0000, 16'h0000);
        queue_request(OP_PUSH, 8'hFF, 1'b1, 7'd1, 16'hFFFF, 16'hFFFF);
        queue_request(OP_PUSH, 8'hA5, 1'b0, 7'd64, 16'h0000, 16'($urandom_range(65535)));
        queue_request(OP_PUSH, 8'h5A, 1'b1, 7'd2, 16'h0000, 16'($urandom_range(65535)));
        queue_request(OP_EDIT, 8'($urandom_range(255)), 1'b1, 7'd64, 16'h0000, 16'hFFFF);
        queue_request(OP_EDIT, 8'($urandom_range(255)), 1'b0, 7'd0, 16'h1234, 16'h0000);
        queue_request(OP_POP, 8'($urandom_range(255)), 1'b0, 7'd0, 16'h0000, 16'h0000);
        queue_request(OP_POP, 8'($urandom_range(255)), 1'b1, 7'd64, 16'hFFFF, 16'hFFFF);
        queue_request(OP_EDIT, 8'($urandom_range(255)), 1'b1, 7'd1, 16'h0000, 16'h0001);
        queue_request(OP_PUSH, 8'h3C, 1'b1, 7'd2, 16'h00FF, 16'h00FF);
        queue_request(OP_PUSH, 8'hC3, 1'b0, 7'd63, 16'hFF00, 16'hFF00);
        queue_request(OP_PUSH, 8'h81, 1'b1, 7'd64, 16'hFF00, 16'hFF00);
        queue_request(OP_POP, 8'($urandom_range(255)), 1'b0, 7'd2, 16'h5555, 16'd2);
        queue_request(OP_PUSH, 8'h7E, 1'b0, 7'd3, 16'hAAAA, 16'hAAAA);
        queue_request(OP_CLEAR, 8'($urandom_range(255)), 1'b1, 7'd3, 16'hAAAA, 16'h5555);
        queue_request(OP_POP, 8'($urandom_range(255)), 1'b0, 7'd0, 16'h0000, 16'hFFFF);
        queue_request(OP_PUSH, 8'h01, 1'b1, 7'd1, 16'h8000, 16'h8000);
        queue_request(OP_EDIT, 8'($urandom_range(255)), 1'b0, 7'd0, 16'h0000, 16'h0000);
        queue_request(OP_CLEAR, 8'($urandom_range(255)), 1'b0, 7'd0, 16'h0000, 16'h0000);
        queue_request(OP_POP, 8'($urandom_range(255)), 1'b1, 7'd1, 16'h0001, 16'hFFFF);
        add_random_traffic(10);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        wait_until_idle();

        send_idle_pct <= 85;
        take_idle_pct <= 27;
        add_random_traffic(10);
        wait_until_idle();

        send_idle_pct <= 0;
        take_idle_pct <= 0;
        queue_request(OP_CLEAR, 8'($urandom_range(255)), 1'b0, 7'd0, 16'h0000, 16'h0000);
        for (k = 0; k < PACKET_SLOTS + 1; k++)
            queue_request(OP_PUSH, 8'($urandom_range(255)), 1'b1, 7'd1, 16'(k),
                          16'($urandom_range(65535)));
        queue_request(OP_POP, 8'($urandom_range(255)), 1'b0, 7'd0, 16'h0000, 16'd1);
        queue_request(OP_CLEAR, 8'($urandom_range(255)), 1'b0, 7'd0, 16'h0000, 16'h0000);
        for (k = 0; k < 5; k++)
            queue_request(OP_PUSH, 8'($urandom_range(255)), k == 4, 7'd5, 16'h0F0F,
                          16'($urandom_range(65535)));
        queue_request(OP_POP, 8'($urandom_range(255)), 1'b0, 7'd0, 16'h0000, 16'd5);
        for (k = 0; k < MAX_PACKET + 1; k++)
            queue_request(OP_PUSH, 8'($urandom_range(255)), 1'b0, 7'd64, 16'h2222,
                          16'($urandom_range(65535)));
        queue_request(OP_PUSH, 8'($urandom_range(255)), 1'b1, 7'd1, 16'h3333,
                      16'($urandom_range(65535)));
        queue_request(OP_POP, 8'($urandom_range(255)), 1'b0, 7'd0, 16'h0000, 16'hFFFF);
        wait_until_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pfl_pkg.sv
hdl/pfl_front.sv
hdl/pfl_outq.sv
hdl/pfl_back.sv
hdl/packet_fifo_with_length_check.sv
dv/tb_top.sv
